// ----- sv/sled_pkg.sv -----
// shared types and constants for the status led activity controller
`default_nettype none

package sled_pkg;

  localparam int NUM_LEDS = 3;

  localparam int PERIOD_W = 16;
  localparam int FLICK_W  = 8;
  localparam int TMO_W    = 16;
  localparam int CHAN_W   = 2;
  localparam int FUNC_W   = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CHAN_W-1:0] RESET_CHANNEL = CHAN_W'(2);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_TICK  = 3'd0,
    FUNC_PROTO = 3'd1,
    FUNC_BUS   = 3'd2,
    FUNC_CHAN  = 3'd3,
    FUNC_CMD   = 3'd4
  } sled_func_t;

  typedef enum logic [1:0] {
    MODE_OFF   = 2'd0,
    MODE_FLASH = 2'd1,
    MODE_ON    = 2'd2
  } sled_mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FLASH_PERIOD  = 2'd0,
    REG_FLICKER_TICKS = 2'd1,
    REG_ACT_TIMEOUT   = 2'd2
  } sled_reg_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] flash_period;
    logic [FLICK_W-1:0]  flicker_ticks;
    logic [TMO_W-1:0]    activity_timeout;
  } sled_cfg_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              bus_on;
    logic [CHAN_W-1:0] channel;
  } sled_evt_t;

  typedef struct packed {
    logic [NUM_LEDS-1:0] led_changed;
    logic [NUM_LEDS-1:0] led_drive;
  } sled_res_t;

endpackage

`default_nettype wire

// ----- sv/sled_core.sv -----
// led state registers and the per-event update logic
`default_nettype none

module sled_core
  import sled_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      step,
  input  wire sled_evt_t evt,
  input  wire sled_cfg_t cfg,
  output sled_res_t      res
);

  sled_mode_t          mode      [NUM_LEDS];
  sled_mode_t          mode_next [NUM_LEDS];
  logic [NUM_LEDS-1:0] lit, lit_next;
  logic [NUM_LEDS-1:0] prev_drive, prev_drive_next;
  logic [FLICK_W-1:0]  flicker      [NUM_LEDS];
  logic [FLICK_W-1:0]  flicker_next [NUM_LEDS];
  logic [TMO_W-1:0]    timeout      [NUM_LEDS];
  logic [TMO_W-1:0]    timeout_next [NUM_LEDS];
  logic [PERIOD_W-1:0] flash_cnt, flash_cnt_next;
  logic                phase, phase_next;
  logic [CHAN_W-1:0]   active, active_next;
  logic [NUM_LEDS-1:0] changed;
  logic                wrap;

  assign wrap = (flash_cnt >= cfg.flash_period);

  always_comb begin
    mode_next       = mode;
    lit_next        = lit;
    prev_drive_next = prev_drive;
    flicker_next    = flicker;
    timeout_next    = timeout;
    flash_cnt_next  = flash_cnt;
    phase_next      = phase;
    active_next     = active;
    changed         = '0;
    unique case (sled_func_t'(evt.func))
      FUNC_TICK: begin
        if (wrap) begin
          flash_cnt_next = '0;
          phase_next     = ~phase;
        end else begin
          flash_cnt_next = flash_cnt + PERIOD_W'(1);
        end
        for (int i = 0; i < NUM_LEDS; i++) begin
          if (timeout[i] != '0) begin
            timeout_next[i] = timeout[i] - TMO_W'(1);
            if (timeout_next[i] == '0 && mode[i] == MODE_ON) begin
              mode_next[i] = MODE_FLASH;
            end
          end
          if (flicker[i] != '0) begin
            flicker_next[i] = flicker[i] - FLICK_W'(1);
          end
          if (wrap && mode_next[i] == MODE_FLASH && flicker_next[i] == '0) begin
            lit_next[i] = phase_next;
          end
          prev_drive_next[i] = lit_next[i] && (flicker_next[i] == '0);
          changed[i]         = prev_drive_next[i] != prev_drive[i];
        end
      end
      FUNC_PROTO, FUNC_CMD: begin
        for (int i = 0; i < NUM_LEDS; i++) begin
          if ((evt.func == FUNC_PROTO && active == CHAN_W'(i)) ||
              (evt.func == FUNC_CMD && i == 0)) begin
            mode_next[i]    = MODE_ON;
            lit_next[i]     = 1'b1;
            flicker_next[i] = cfg.flicker_ticks;
            timeout_next[i] = cfg.activity_timeout;
          end
        end
      end
      FUNC_BUS: begin
        for (int i = 0; i < NUM_LEDS; i++) begin
          if (active == CHAN_W'(i)) begin
            mode_next[i] = evt.bus_on ? MODE_ON : MODE_OFF;
          end
        end
      end
      FUNC_CHAN: begin
        if (evt.channel < CHAN_W'(NUM_LEDS)) begin
          active_next = evt.channel;
        end
      end
      default: begin
      end
    endcase
  end

  assign res.led_drive   = prev_drive_next;
  assign res.led_changed = changed;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_LEDS; i++) begin
        mode[i]    <= (i == 0) ? MODE_FLASH : MODE_OFF;
        flicker[i] <= '0;
        timeout[i] <= '0;
      end
      lit        <= '0;
      prev_drive <= '0;
      flash_cnt  <= '0;
      phase      <= 1'b0;
      active     <= RESET_CHANNEL;
    end else if (step) begin
      mode       <= mode_next;
      flicker    <= flicker_next;
      timeout    <= timeout_next;
      lit        <= lit_next;
      prev_drive <= prev_drive_next;
      flash_cnt  <= flash_cnt_next;
      phase      <= phase_next;
      active     <= active_next;
    end
  end

endmodule

`default_nettype wire

// ----- sv/status_led_activity_controller.sv -----
// top level: event stream in, led drive stream out, register write port
//
// channel  dir  handshake            payload
// s_       in   s_tvalid/s_tready    s_tuser func, s_tdata bus_on, channel
// m_       out  m_tvalid/m_tready    m_tdata led_drive, led_changed
// cfg_     in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// one event per cycle while the result side is not stalled; an input beat goes
// through the input register, then the led update into the result register
// rst is synchronous: leds 1 and 2 off, led 0 flashing, active led 2
// a stalled result holds both stages; the input stage still takes a beat
// while it is empty, register writes are taken on every cycle
`default_nettype none

module status_led_activity_controller
  import sled_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [7:0]            s_tdata,   // bus_on, channel[1:0], zero fill
  input  wire logic [FUNC_W-1:0]     s_tuser,   // func
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [7:0]                 m_tdata,   // led_drive[2:0], led_changed[2:0], zero fill
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int RES_W = 2 * NUM_LEDS;

  sled_cfg_t cfg;
  sled_evt_t in_evt;
  sled_res_t res;
  logic      in_valid;
  logic      out_free;
  logic      step;

  assign cfg_ready = 1'b1;
  assign out_free  = !m_tvalid || m_tready;
  assign step      = in_valid && out_free;
  assign s_tready  = !in_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.flash_period     <= PERIOD_W'(50);
      cfg.flicker_ticks    <= FLICK_W'(5);
      cfg.activity_timeout <= TMO_W'(1000);
    end else if (cfg_valid && cfg_ready) begin
      unique case (sled_reg_t'(cfg_index))
        REG_FLASH_PERIOD:  cfg.flash_period     <= cfg_data[PERIOD_W-1:0];
        REG_FLICKER_TICKS: cfg.flicker_ticks    <= cfg_data[FLICK_W-1:0];
        REG_ACT_TIMEOUT:   cfg.activity_timeout <= cfg_data[TMO_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_evt.func    <= s_tuser;
      in_evt.bus_on  <= s_tdata[0];
      in_evt.channel <= s_tdata[CHAN_W:1];
    end
  end

  sled_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .evt  (in_evt),
    .cfg  (cfg),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      m_tdata <= {(8 - RES_W)'(0), res.led_changed, res.led_drive};
    end
  end

endmodule

`default_nettype wire

// ----- sv/sled_checker.sv -----
// port-level checks on the status led activity controller, bound to the top level
`default_nettype none

module sled_checker
  import sled_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  s_tvalid,
  input wire logic                  s_tready,
  input wire logic [7:0]            s_tdata,
  input wire logic [FUNC_W-1:0]     s_tuser,
  input wire logic                  m_tvalid,
  input wire logic                  m_tready,
  input wire logic [7:0]            m_tdata,
  input wire logic                  cfg_valid,
  input wire logic                  cfg_ready,
  input wire logic [CFG_IDX_W-1:0]  cfg_index,
  input wire logic [CFG_DATA_W-1:0] cfg_data
);

  // no result straight after reset
  a_reset_clears_out: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // an empty result register never blocks the input side
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

  // a beat taken with the output empty gives a result through the input register, then the result register
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && !m_tvalid) ##1 (!m_tvalid || m_tready) |=> m_tvalid)
    else $error("result missing after accepted beat");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

endmodule

bind status_led_activity_controller sled_checker u_sled_checker (.*);

`default_nettype wire

// ----- sim/status_led_activity_controller_tb.sv -----
// self-checking bench for the status led controller: event table, random events, led model
`timescale 1ns / 1ps

module status_led_activity_controller_tb;
  import sled_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_SPARE_LO  = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_MID = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_HI  = 3'd7;

  localparam logic [PERIOD_W-1:0] PERIOD_AT_RESET  = 16'd50;
  localparam logic [FLICK_W-1:0]  FLICKER_AT_RESET = 8'd5;
  localparam logic [TMO_W-1:0]    TIMEOUT_AT_RESET = 16'd1000;

  typedef struct packed {
    sled_evt_t ev;
    logic      typed;
    sled_res_t res;
  } step_row_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata = '0;
  logic [FUNC_W-1:0]     s_tuser = FUNC_TICK;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [7:0]            m_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_FLASH_PERIOD;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int send_gap_pct = 25;
  int recv_stall_pct = 81;
  int mismatches = 0;

  sled_res_t led_results_q[$];

  // led model state
  sled_mode_t          lamp_mode [NUM_LEDS];
  logic                lamp_lit [NUM_LEDS];
  logic                lamp_drive [NUM_LEDS];
  logic [FLICK_W-1:0]  dark_left [NUM_LEDS];
  logic [TMO_W-1:0]    hold_left [NUM_LEDS];
  logic [PERIOD_W-1:0] phase_ticks;
  logic                phase_bit;
  logic [CHAN_W-1:0]   sel_led;
  logic [PERIOD_W-1:0] cur_period;
  logic [FLICK_W-1:0]  cur_flicker;
  logic [TMO_W-1:0]    cur_timeout;

  status_led_activity_controller uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic void reset_leds();
    for (int i = 0; i < NUM_LEDS; i++) begin
      lamp_mode[i]  = MODE_OFF;
      lamp_lit[i]   = 1'b0;
      lamp_drive[i] = 1'b0;
      dark_left[i]  = '0;
      hold_left[i]  = '0;
    end
    lamp_mode[0] = MODE_FLASH;
    phase_ticks  = '0;
    phase_bit    = 1'b0;
    sel_led      = RESET_CHANNEL;
    cur_period   = PERIOD_AT_RESET;
    cur_flicker  = FLICKER_AT_RESET;
    cur_timeout  = TIMEOUT_AT_RESET;
  endfunction

  function automatic void light_up(input int idx);
    if (idx < NUM_LEDS) begin
      lamp_mode[idx] = MODE_ON;
      lamp_lit[idx]  = 1'b1;
      dark_left[idx] = cur_flicker;
      hold_left[idx] = cur_timeout;
    end
  endfunction

  function automatic sled_res_t step_leds(input sled_evt_t ev);
    sled_res_t r;
    logic      d;
    r = '0;
    case (ev.func)
      FUNC_TICK: begin
        for (int i = 0; i < NUM_LEDS; i++) begin
          if (hold_left[i] != 0) begin
            hold_left[i] = hold_left[i] - 1'b1;
            if (hold_left[i] == 0 && lamp_mode[i] == MODE_ON)
              lamp_mode[i] = MODE_FLASH;
          end
          if (dark_left[i] != 0)
            dark_left[i] = dark_left[i] - 1'b1;
        end
        if (phase_ticks >= cur_period) begin
          phase_ticks = '0;
          phase_bit   = ~phase_bit;
          for (int i = 0; i < NUM_LEDS; i++)
            if (lamp_mode[i] == MODE_FLASH && dark_left[i] == 0)
              lamp_lit[i] = phase_bit;
        end else begin
          phase_ticks = phase_ticks + 1'b1;
        end
        for (int i = 0; i < NUM_LEDS; i++) begin
          d = lamp_lit[i] && (dark_left[i] == 0);
          if (d != lamp_drive[i]) begin
            lamp_drive[i]     = d;
            r.led_changed[i] = 1'b1;
          end
        end
      end
      FUNC_PROTO: light_up(int'(sel_led));
      FUNC_BUS: begin
        if (sel_led < NUM_LEDS)
          lamp_mode[sel_led] = ev.bus_on ? MODE_ON : MODE_OFF;
      end
      FUNC_CHAN: begin
        if (ev.channel < NUM_LEDS)
          sel_led = ev.channel;
      end
      FUNC_CMD: light_up(0);
      default: ;
    endcase
    for (int i = 0; i < NUM_LEDS; i++)
      r.led_drive[i] = lamp_drive[i];
    return r;
  endfunction

  function automatic step_row_t row(input logic [FUNC_W-1:0] func, input logic bus_on,
                                    input logic [CHAN_W-1:0] channel, input logic typed,
                                    input logic [NUM_LEDS-1:0] drive,
                                    input logic [NUM_LEDS-1:0] changed);
    step_row_t r;
    r.ev.func            = func;
    r.ev.bus_on          = bus_on;
    r.ev.channel         = channel;
    r.typed              = typed;
    r.res.led_drive      = drive;
    r.res.led_changed    = changed;
    return r;
  endfunction

  function automatic sled_evt_t random_event();
    sled_evt_t e;
    int        roll;
    roll      = int'($urandom_range(99));
    e.bus_on  = 1'($urandom_range(1));
    e.channel = CHAN_W'($urandom_range(3));
    if (roll < 55)
      e.func = FUNC_TICK;
    else if (roll < 67)
      e.func = FUNC_PROTO;
    else if (roll < 77)
      e.func = FUNC_BUS;
    else if (roll < 87)
      e.func = FUNC_CHAN;
    else if (roll < 95)
      e.func = FUNC_CMD;
    else
      e.func = FUNC_W'($urandom_range(FUNC_SPARE_HI, FUNC_SPARE_LO));
    return e;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic send_event(input sled_evt_t ev, input logic typed, input sled_res_t given);
    sled_res_t calc;
    @(negedge clk);
    while ($urandom_range(99) < send_gap_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= ev.func;
    s_tdata  <= {5'b0, ev.channel, ev.bus_on};
    do @(posedge clk); while (!s_tready);
    calc = step_leds(ev);
    led_results_q.push_back(typed ? given : calc);
  endtask

  task automatic write_reg(input sled_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_FLASH_PERIOD:  cur_period  = val;
      REG_FLICKER_TICKS: cur_flicker = val[FLICK_W-1:0];
      REG_ACT_TIMEOUT:   cur_timeout = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_config(input logic [PERIOD_W-1:0] period, input logic [FLICK_W-1:0] flicker,
                            input logic [TMO_W-1:0] timeout);
    write_reg(REG_FLASH_PERIOD, period);
    write_reg(REG_FLICKER_TICKS, {8'd0, flicker});
    write_reg(REG_ACT_TIMEOUT, timeout);
  endtask

  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (led_results_q.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  always @(negedge clk)
    m_tready <= ($urandom_range(99) >= recv_stall_pct);

  // result beat check
  always @(posedge clk) begin
    sled_res_t got;
    sled_res_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[5:0];
      if (led_results_q.size() == 0) begin
        report_mismatch($sformatf("unexpected beat drive=%b changed=%b",
                                  got.led_drive, got.led_changed));
      end else begin
        want = led_results_q.pop_front();
        if (got.led_drive !== want.led_drive)
          report_mismatch($sformatf("led_drive got %b want %b", got.led_drive, want.led_drive));
        if (got.led_changed !== want.led_changed)
          report_mismatch($sformatf("led_changed got %b want %b",
                                    got.led_changed, want.led_changed));
      end
    end
  end

  initial begin
    step_row_t           plan[$];
    sled_res_t           none;
    sled_evt_t           ev;
    logic [PERIOD_W-1:0] period;
    logic [FLICK_W-1:0]  flicker;
    logic [TMO_W-1:0]    timeout;
    int                  setting;

    none = '0;
    reset_leds();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    plan.push_back(row(FUNC_TICK,      1'b0, 2'd0, 1'b1, 3'b000, 3'b000));
    plan.push_back(row(FUNC_SPARE_LO,  1'b1, 2'd3, 1'b1, 3'b000, 3'b000));
    plan.push_back(row(FUNC_SPARE_HI,  1'b1, 2'd3, 1'b1, 3'b000, 3'b000));
    plan.push_back(row(FUNC_SPARE_MID, 1'b0, 2'd1, 1'b1, 3'b000, 3'b000));
    // channel 3 is out of range and leaves led 2 selected
    plan.push_back(row(FUNC_CHAN,      1'b0, 2'd3, 1'b1, 3'b000, 3'b000));
    plan.push_back(row(FUNC_CMD,       1'b0, 2'd0, 1'b1, 3'b000, 3'b000));
    plan.push_back(row(FUNC_PROTO,     1'b0, 2'd0, 1'b1, 3'b000, 3'b000));
    repeat (6) plan.push_back(row(FUNC_TICK, 1'b0, 2'd0, 1'b0, 3'b000, 3'b000));
    plan.push_back(row(FUNC_CHAN,      1'b1, 2'd1, 1'b0, 3'b000, 3'b000));
    plan.push_back(row(FUNC_BUS,       1'b1, 2'd2, 1'b0, 3'b000, 3'b000));
    plan.push_back(row(FUNC_TICK,      1'b0, 2'd0, 1'b0, 3'b000, 3'b000));
    plan.push_back(row(FUNC_BUS,       1'b0, 2'd0, 1'b0, 3'b000, 3'b000));
    plan.push_back(row(FUNC_CHAN,      1'b0, 2'd0, 1'b0, 3'b000, 3'b000));
    plan.push_back(row(FUNC_BUS,       1'b0, 2'd3, 1'b0, 3'b000, 3'b000));
    plan.push_back(row(FUNC_TICK,      1'b1, 2'd3, 1'b0, 3'b000, 3'b000));
    plan.push_back(row(FUNC_CHAN,      1'b1, 2'd2, 1'b0, 3'b000, 3'b000));
    plan.push_back(row(FUNC_PROTO,     1'b1, 2'd3, 1'b0, 3'b000, 3'b000));
    plan.push_back(row(FUNC_TICK,      1'b0, 2'd0, 1'b0, 3'b000, 3'b000));
    plan.push_back(row(FUNC_SPARE_LO,  1'b1, 2'd0, 1'b0, 3'b000, 3'b000));

    foreach (plan[i])
      send_event(plan[i].ev, plan[i].typed, plan[i].res);
    drain();

    for (int sched = 0; sched < 3; sched++) begin
      case (sched)
        0: begin send_gap_pct = 25; recv_stall_pct = 81; end
        1: begin send_gap_pct = 81; recv_stall_pct = 25; end
        default: begin send_gap_pct = 0; recv_stall_pct = 0; end
      endcase
      for (int k = 0; k < 3; k++) begin
        setting = sched * 3 + k;
        if (setting == 0) begin
          period = '0; flicker = '0; timeout = '0;
        end else if (setting == 4) begin
          period = '1; flicker = '1; timeout = '1;
        end else begin
          period  = PERIOD_W'($urandom_range(6));
          flicker = FLICK_W'($urandom_range(6));
          timeout = TMO_W'($urandom_range(40));
        end
        set_config(period, flicker, timeout);
        repeat (145) send_event(random_event(), 1'b0, none);
        drain();
      end
    end

    // longest flash period, flicker and timeout: kicked leds stay dark and held on
    set_config('1, '1, '1);
    ev = '0;
    ev.func = FUNC_CMD;
    send_event(ev, 1'b0, none);
    ev.func = FUNC_PROTO;
    send_event(ev, 1'b0, none);
    ev.func = FUNC_TICK;
    repeat (20) send_event(ev, 1'b0, none);
    drain();
    repeat (8) @(posedge clk);

    if (mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

// ----- sim.f -----
sv/sled_pkg.sv
sv/sled_core.sv
sv/status_led_activity_controller.sv
sv/sled_checker.sv
sim/status_led_activity_controller_tb.sv
